[rtl/assert_macros.svh]
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define SLMT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define SLMT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/slmt_pkg.sv]
// Package: shared constants and codes for the sorted line mark table
package slmt_pkg;

    localparam int MAX_MARKS_DEF = 256;
    localparam int LINE_BITS_DEF = 32;

    localparam int FIELD_W = 32;
    localparam int OPC_W   = 3;
    localparam int STAT_W  = 2;
    localparam int NTF_W   = 2;
    localparam int MCNT_W  = 9;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OPC_W-1:0] OP_MARK   = 3'd1;
    localparam logic [OPC_W-1:0] OP_TOGGLE = 3'd2;
    localparam logic [OPC_W-1:0] OP_TEST   = 3'd3;
    localparam logic [OPC_W-1:0] OP_FIND   = 3'd4;
    localparam logic [OPC_W-1:0] OP_ERASE  = 3'd5;
    localparam logic [OPC_W-1:0] OP_INSERT = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Notify codes
    localparam logic [NTF_W-1:0] NT_NONE  = 2'd0;
    localparam logic [NTF_W-1:0] NT_LINE  = 2'd1;
    localparam logic [NTF_W-1:0] NT_ALL   = 2'd2;

endpackage

[rtl/slmt_ram.sv]
// Generic single-write, single-read RAM with registered read data
module slmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sorted_line_mark_table.sv]
// Sorted line mark table: one item at a time, table held in a synchronous RAM
// Clear, out-of-range and unused items go straight to the result; test runs a lower bound
//   search, a find also reads the found mark, and a wrapping find first reduces its count.
// Edits move one entry a cycle through the RAM as marks, erases and inserts shift entries.
// Next item is taken the cycle after the result is loaded; a stalled result holds it off.
// Reset clears the mark count, line_count and the output; RAM contents stay
//   undefined and are never used beyond the held marks.
module sorted_line_mark_table #(
    parameter int MAX_MARKS = slmt_pkg::MAX_MARKS_DEF,
    parameter int LINE_BITS = slmt_pkg::LINE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [slmt_pkg::FIELD_W-1:0]   cfg_data,
    // input items
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [slmt_pkg::OPC_W-1:0]     opcode,
    input  logic [slmt_pkg::FIELD_W-1:0]   line,
    input  logic [slmt_pkg::FIELD_W-1:0]   end_line,
    input  logic                           starts_mid_line,
    input  logic                           set_flag,
    input  logic                           backward,
    input  logic                           wrap,
    input  logic [slmt_pkg::FIELD_W-1:0]   count,
    // results
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [slmt_pkg::STAT_W-1:0]    status,
    output logic                           found,
    output logic [slmt_pkg::FIELD_W-1:0]   found_line,
    output logic [slmt_pkg::NTF_W-1:0]     notify,
    output logic [slmt_pkg::MCNT_W-1:0]    mark_count
);

    localparam int LW = LINE_BITS;
    localparam int IW = $clog2(MAX_MARKS);
    localparam int CW = $clog2(MAX_MARKS + 1);
    localparam int FW = slmt_pkg::FIELD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_BS, S_BS_CMP, S_PEEK_RD, S_PEEK,
        S_DECIDE, S_MOVE, S_INS_WR, S_FIND, S_OUT
    } state_t;

    typedef enum logic [1:0] {MV_COPY, MV_ADD, MV_SUB} mv_mode_t;

    state_t   state_reg, state_next;
    mv_mode_t mv_mode_reg, mv_mode_next;

    logic [slmt_pkg::OPC_W-1:0]  op_reg, op_next;
    logic [LW-1:0]   ln_reg, ln_next, el_reg, el_next;
    logic            smid_reg, smid_next, setf_reg, setf_next;
    logic            back_reg, back_next, wrap_reg, wrap_next, cz_reg, cz_next;
    logic [FW-1:0]   cnt_reg, cnt_next, line_count_reg, line_count_next;
    logic [CW-1:0]   held_reg, held_next;
    logic [LW:0]     key_reg, key_next;
    logic [CW-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [IW-1:0]   bmid_reg, bmid_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic            hit_reg, hit_next;
    logic [CW-1:0]   ceff_reg, ceff_next, rem_reg, rem_next;
    logic [4:0]      bit_reg, bit_next;
    logic [CW-1:0]   a_reg, a_next;
    logic            second_reg, second_next;
    logic [IW-1:0]   mv_src_reg, mv_src_next, mv_pidx_reg, mv_pidx_next;
    logic [IW-1:0]   mv_off_reg, mv_off_next;
    logic [CW-1:0]   mv_left_reg, mv_left_next;
    logic            mv_pend_reg, mv_pend_next, mv_down_reg, mv_down_next;
    logic            mv_ins_reg, mv_ins_next;
    logic [slmt_pkg::STAT_W-1:0] r_status_reg, r_status_next;
    logic            r_found_reg, r_found_next;
    logic [FW-1:0]   r_fline_reg, r_fline_next;
    logic [slmt_pkg::NTF_W-1:0]  r_notify_reg, r_notify_next;
    logic            out_valid_reg, out_valid_next;
    logic [slmt_pkg::STAT_W-1:0] status_reg, status_next;
    logic            found_reg, found_next;
    logic [FW-1:0]   fline_reg, fline_next;
    logic [slmt_pkg::NTF_W-1:0]  notify_reg, notify_next;
    logic [slmt_pkg::MCNT_W-1:0] mcnt_reg, mcnt_next;

    // RAM port signals
    logic            ram_we;
    logic [IW-1:0]   ram_waddr, ram_raddr;
    logic [LW-1:0]   ram_wdata, ram_rdata;

    // combinational helpers
    logic [LW-1:0]   ln_in, el_in, nl;
    logic            accept;
    logic [CW-1:0]   bs_mid, b_pos, ins_pos;
    logic [CW:0]     n1, p1, c1, p0, cstep, fsum, fp, mod_t;
    logic            fok;
    logic [LW:0]     add_sum;

    slmt_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_MARKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ln_in  = LW'(line);
    assign el_in  = LW'(end_line);
    assign nl     = el_reg - ln_reg;
    assign accept = in_valid && !in_stall;
    assign n1     = {1'b0, held_reg};
    assign p1     = {1'b0, pos_reg};
    assign c1     = {1'b0, ceff_reg};
    assign bs_mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign b_pos  = (pos_reg > a_reg) ? pos_reg : a_reg;
    assign ins_pos = pos_reg + CW'(hit_reg && smid_reg);
    assign mod_t  = {rem_reg, cnt_reg[FW-1]};
    assign add_sum = {1'b0, ram_rdata} + {1'b0, nl};

    // find: final position from the search result and the step count
    always_comb
    begin
        fok   = 1'b1;
        fp    = '0;
        p0    = p1;
        cstep = c1;
        fsum  = '0;
        if (!back_reg)
        begin
            if (p1 == n1)
            begin
                fok   = wrap_reg;
                p0    = '0;
                cstep = c1 - 1'b1;
            end
            else if (!hit_reg)
            begin
                cstep = c1 - 1'b1;
            end
            fsum = p0 + cstep;
            if (fsum >= n1)
            begin
                if (wrap_reg)
                begin
                    fp = fsum - n1;
                end
                else
                begin
                    fok = 1'b0;
                end
            end
            else
            begin
                fp = fsum;
            end
        end
        else
        begin
            if (p1 < c1)
            begin
                fok = wrap_reg;
                fp  = p1 + n1 - c1;
            end
            else
            begin
                fp = p1 - c1;
            end
        end
    end

    // sequencer: next state, RAM access and result capture
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        ln_next         = ln_reg;
        el_next         = el_reg;
        smid_next       = smid_reg;
        setf_next       = setf_reg;
        back_next       = back_reg;
        wrap_next       = wrap_reg;
        cz_next         = cz_reg;
        cnt_next        = cnt_reg;
        line_count_next = line_count_reg;
        held_next       = held_reg;
        key_next        = key_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        bmid_next       = bmid_reg;
        pos_next        = pos_reg;
        hit_next        = hit_reg;
        ceff_next       = ceff_reg;
        rem_next        = rem_reg;
        bit_next        = bit_reg;
        a_next          = a_reg;
        second_next     = second_reg;
        mv_src_next     = mv_src_reg;
        mv_pidx_next    = mv_pidx_reg;
        mv_off_next     = mv_off_reg;
        mv_left_next    = mv_left_reg;
        mv_pend_next    = mv_pend_reg;
        mv_down_next    = mv_down_reg;
        mv_ins_next     = mv_ins_reg;
        mv_mode_next    = mv_mode_reg;
        r_status_next   = r_status_reg;
        r_found_next    = r_found_reg;
        r_fline_next    = r_fline_reg;
        r_notify_next   = r_notify_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        found_next      = found_reg;
        fline_next      = fline_reg;
        notify_next     = notify_reg;
        mcnt_next       = mcnt_reg;
        ram_we          = 1'b0;
        ram_waddr       = mv_pidx_reg + mv_off_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = mv_src_reg;

        if (cfg_valid)
        begin
            line_count_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = opcode;
                    ln_next       = ln_in;
                    el_next       = el_in;
                    smid_next     = starts_mid_line;
                    setf_next     = set_flag;
                    back_next     = backward;
                    wrap_next     = wrap;
                    cz_next       = (count == '0);
                    cnt_next      = count;
                    ceff_next     = CW'(count);
                    rem_next      = '0;
                    bit_next      = '0;
                    second_next   = 1'b0;
                    key_next      = {1'b0, ln_in};
                    lo_next       = '0;
                    hi_next       = held_reg;
                    r_status_next = slmt_pkg::ST_OK;
                    r_found_next  = 1'b0;
                    r_fline_next  = '0;
                    r_notify_next = slmt_pkg::NT_NONE;
                    state_next    = S_OUT;
                    if ((opcode == slmt_pkg::OP_MARK || opcode == slmt_pkg::OP_TOGGLE ||
                         opcode == slmt_pkg::OP_TEST || opcode == slmt_pkg::OP_FIND) &&
                        (FW'(ln_in) >= line_count_reg))
                    begin
                        r_status_next = slmt_pkg::ST_RANGE;
                    end
                    else
                    begin
                        unique case (opcode) inside
                            slmt_pkg::OP_CLEAR:
                            begin
                                if (held_reg != '0)
                                begin
                                    held_next     = '0;
                                    r_notify_next = slmt_pkg::NT_ALL;
                                end
                            end
                            slmt_pkg::OP_MARK, slmt_pkg::OP_TOGGLE, slmt_pkg::OP_TEST:
                            begin
                                state_next = S_BS;
                            end
                            slmt_pkg::OP_FIND:
                            begin
                                if (held_reg == '0)
                                begin
                                    state_next = S_OUT;
                                end
                                else if (count > FW'(held_reg))
                                begin
                                    state_next = wrap ? S_MOD : S_OUT;
                                end
                                else
                                begin
                                    state_next = S_BS;
                                end
                            end
                            slmt_pkg::OP_ERASE:
                            begin
                                key_next = {1'b0, ln_in} + (LW+1)'(starts_mid_line);
                                if (el_in > ln_in && held_reg != '0)
                                begin
                                    state_next = S_BS;
                                end
                            end
                            slmt_pkg::OP_INSERT:
                            begin
                                if (el_in > ln_in && held_reg != '0)
                                begin
                                    state_next = S_BS;
                                end
                            end
                            default:
                            begin
                                state_next = S_OUT;
                            end
                        endcase
                    end
                end
            end

            // count modulo marks held, one quotient bit a cycle
            S_MOD:
            begin
                rem_next = (mod_t >= n1) ? CW'(mod_t - n1) : CW'(mod_t);
                cnt_next = cnt_reg << 1;
                bit_next = bit_reg + 1'b1;
                if (bit_reg == 5'd31)
                begin
                    ceff_next  = (rem_next == '0) ? held_reg : rem_next;
                    state_next = S_BS;
                end
            end

            // lower bound search over the held marks
            S_BS:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_raddr  = IW'(bs_mid);
                    bmid_next  = IW'(bs_mid);
                    state_next = S_BS_CMP;
                end
                else
                begin
                    pos_next   = lo_reg;
                    state_next = S_PEEK_RD;
                end
            end

            S_BS_CMP:
            begin
                if ({1'b0, ram_rdata} < key_reg)
                begin
                    lo_next = CW'(bmid_reg) + 1'b1;
                end
                else
                begin
                    hi_next = CW'(bmid_reg);
                end
                state_next = S_BS;
            end

            // read the entry at the search position
            S_PEEK_RD:
            begin
                ram_raddr = IW'(pos_reg);
                if (pos_reg < held_reg)
                begin
                    state_next = S_PEEK;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = S_DECIDE;
                end
            end

            S_PEEK:
            begin
                hit_next   = (ram_rdata == ln_reg);
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                state_next   = S_OUT;
                mv_pend_next = 1'b0;
                mv_ins_next  = 1'b0;
                mv_down_next = 1'b0;
                mv_mode_next = MV_COPY;
                unique case (op_reg) inside
                    slmt_pkg::OP_MARK, slmt_pkg::OP_TOGGLE:
                    begin
                        if (hit_reg)
                        begin
                            if (op_reg == slmt_pkg::OP_TOGGLE || !setf_reg)
                            begin
                                r_notify_next = slmt_pkg::NT_LINE;
                                held_next     = held_reg - 1'b1;
                                mv_src_next   = IW'(pos_reg + 1'b1);
                                mv_left_next  = held_reg - pos_reg - 1'b1;
                                mv_off_next   = '1;
                                state_next    = S_MOVE;
                            end
                        end
                        else if (op_reg == slmt_pkg::OP_TOGGLE || setf_reg)
                        begin
                            if (held_reg >= CW'(MAX_MARKS))
                            begin
                                r_status_next = slmt_pkg::ST_FULL;
                            end
                            else
                            begin
                                r_notify_next = slmt_pkg::NT_LINE;
                                held_next     = held_reg + 1'b1;
                                mv_src_next   = IW'(held_reg - 1'b1);
                                mv_left_next  = held_reg - pos_reg;
                                mv_off_next   = IW'(1);
                                mv_down_next  = 1'b1;
                                mv_ins_next   = 1'b1;
                                state_next    = S_MOVE;
                            end
                        end
                    end
                    slmt_pkg::OP_TEST:
                    begin
                        r_found_next = hit_reg;
                        r_fline_next = hit_reg ? FW'(ln_reg) : '0;
                    end
                    slmt_pkg::OP_FIND:
                    begin
                        if (cz_reg)
                        begin
                            r_found_next = hit_reg;
                            r_fline_next = hit_reg ? FW'(ln_reg) : '0;
                        end
                        else if (fok && fp < n1)
                        begin
                            ram_raddr  = IW'(fp);
                            state_next = S_FIND;
                        end
                    end
                    slmt_pkg::OP_ERASE:
                    begin
                        if (!second_reg)
                        begin
                            if (pos_reg < held_reg)
                            begin
                                a_next      = pos_reg;
                                key_next    = {1'b0, el_reg} + 1'b1;
                                lo_next     = '0;
                                hi_next     = held_reg;
                                second_next = 1'b1;
                                state_next  = S_BS;
                            end
                        end
                        else
                        begin
                            held_next    = a_reg + held_reg - b_pos;
                            mv_src_next  = IW'(b_pos);
                            mv_left_next = held_reg - b_pos;
                            mv_off_next  = IW'(a_reg - b_pos);
                            mv_mode_next = MV_SUB;
                            state_next   = S_MOVE;
                        end
                    end
                    slmt_pkg::OP_INSERT:
                    begin
                        mv_src_next  = IW'(ins_pos);
                        mv_left_next = held_reg - ins_pos;
                        mv_off_next  = '0;
                        mv_mode_next = MV_ADD;
                        state_next   = S_MOVE;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end

            // entry move loop: read one entry a cycle, write it in the cycle after its read
            S_MOVE:
            begin
                if (mv_pend_reg)
                begin
                    case (mv_mode_reg)
                        MV_ADD:  ram_wdata = LW'(add_sum);
                        MV_SUB:  ram_wdata = ram_rdata - nl;
                        default: ram_wdata = ram_rdata;
                    endcase
                    ram_we = !(mv_mode_reg == MV_ADD && add_sum[LW]);
                end
                if (mv_pend_reg && mv_mode_reg == MV_ADD && add_sum[LW])
                begin
                    // marks from here on would pass the largest line: drop them
                    held_next    = CW'(mv_pidx_reg);
                    mv_pend_next = 1'b0;
                    state_next   = S_OUT;
                end
                else if (mv_left_reg != '0)
                begin
                    mv_src_next  = mv_down_reg ? mv_src_reg - 1'b1 : mv_src_reg + 1'b1;
                    mv_left_next = mv_left_reg - 1'b1;
                    mv_pend_next = 1'b1;
                    mv_pidx_next = mv_src_reg;
                end
                else
                begin
                    mv_pend_next = 1'b0;
                    if (!mv_pend_reg)
                    begin
                        state_next = mv_ins_reg ? S_INS_WR : S_OUT;
                    end
                end
            end

            S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = IW'(pos_reg);
                ram_wdata  = ln_reg;
                state_next = S_OUT;
            end

            S_FIND:
            begin
                r_found_next = 1'b1;
                r_fline_next = FW'(ram_rdata);
                state_next   = S_OUT;
            end

            // hand the result to the output register once it is free
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = r_status_reg;
                    found_next     = r_found_reg;
                    fline_next     = r_fline_reg;
                    notify_next    = r_notify_reg;
                    mcnt_next      = slmt_pkg::MCNT_W'(held_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mv_mode_reg    <= MV_COPY;
            op_reg         <= '0;
            ln_reg         <= '0;
            el_reg         <= '0;
            smid_reg       <= 1'b0;
            setf_reg       <= 1'b0;
            back_reg       <= 1'b0;
            wrap_reg       <= 1'b0;
            cz_reg         <= 1'b0;
            cnt_reg        <= '0;
            line_count_reg <= '0;
            held_reg       <= '0;
            key_reg        <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            bmid_reg       <= '0;
            pos_reg        <= '0;
            hit_reg        <= 1'b0;
            ceff_reg       <= '0;
            rem_reg        <= '0;
            bit_reg        <= '0;
            a_reg          <= '0;
            second_reg     <= 1'b0;
            mv_src_reg     <= '0;
            mv_pidx_reg    <= '0;
            mv_off_reg     <= '0;
            mv_left_reg    <= '0;
            mv_pend_reg    <= 1'b0;
            mv_down_reg    <= 1'b0;
            mv_ins_reg     <= 1'b0;
            r_status_reg   <= '0;
            r_found_reg    <= 1'b0;
            r_fline_reg    <= '0;
            r_notify_reg   <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= '0;
            found_reg      <= 1'b0;
            fline_reg      <= '0;
            notify_reg     <= '0;
            mcnt_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mv_mode_reg    <= mv_mode_next;
            op_reg         <= op_next;
            ln_reg         <= ln_next;
            el_reg         <= el_next;
            smid_reg       <= smid_next;
            setf_reg       <= setf_next;
            back_reg       <= back_next;
            wrap_reg       <= wrap_next;
            cz_reg         <= cz_next;
            cnt_reg        <= cnt_next;
            line_count_reg <= line_count_next;
            held_reg       <= held_next;
            key_reg        <= key_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            bmid_reg       <= bmid_next;
            pos_reg        <= pos_next;
            hit_reg        <= hit_next;
            ceff_reg       <= ceff_next;
            rem_reg        <= rem_next;
            bit_reg        <= bit_next;
            a_reg          <= a_next;
            second_reg     <= second_next;
            mv_src_reg     <= mv_src_next;
            mv_pidx_reg    <= mv_pidx_next;
            mv_off_reg     <= mv_off_next;
            mv_left_reg    <= mv_left_next;
            mv_pend_reg    <= mv_pend_next;
            mv_down_reg    <= mv_down_next;
            mv_ins_reg     <= mv_ins_next;
            r_status_reg   <= r_status_next;
            r_found_reg    <= r_found_next;
            r_fline_reg    <= r_fline_next;
            r_notify_reg   <= r_notify_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            found_reg      <= found_next;
            fline_reg      <= fline_next;
            notify_reg     <= notify_next;
            mcnt_reg       <= mcnt_next;
        end
    end

    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign found      = found_reg;
    assign found_line = fline_reg;
    assign notify     = notify_reg;
    assign mark_count = mcnt_reg;

endmodule

[rtl/slmt_chk.sv]
// Port checker for the sorted line mark table, bound to the top level
`include "assert_macros.svh"

module slmt_chk #(
    parameter int MAX_MARKS = slmt_pkg::MAX_MARKS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [slmt_pkg::STAT_W-1:0]  status,
    input logic                         found,
    input logic [slmt_pkg::FIELD_W-1:0] found_line,
    input logic [slmt_pkg::NTF_W-1:0]   notify,
    input logic [slmt_pkg::MCNT_W-1:0]  mark_count
);

    // a stalled result stays offered
    `SLMT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

    // no mark found means a zero line
    `SLMT_ASSERT(a_fline_zero, out_valid && !found |-> found_line == '0, "found_line set without find")

    // clearing everything leaves no marks
    `SLMT_ASSERT(a_clear_empty, out_valid && notify == slmt_pkg::NT_ALL |-> mark_count == '0, "marks left after clear")

    // a full table rejects without change
    `SLMT_ASSERT(a_full, out_valid && status == slmt_pkg::ST_FULL |-> notify == slmt_pkg::NT_NONE && mark_count == slmt_pkg::MCNT_W'(MAX_MARKS), "full status with odd count")

    // out of range changes and finds nothing
    `SLMT_ASSERT(a_range, out_valid && status == slmt_pkg::ST_RANGE |-> !found && notify == slmt_pkg::NT_NONE, "out of range item had an effect")

endmodule

bind sorted_line_mark_table slmt_chk #(.MAX_MARKS(MAX_MARKS)) u_slmt_chk (.*);
